>>> rtl/krt_pkg.sv
package krt_pkg;

  // Operation codes on in_operation
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Result status codes on out_status
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FIRED    = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;
  localparam logic [2:0] ST_CLEARED  = 3'd7;

  // Most fired beats reported for one tick
  localparam int RESULT_CAP = 16;
  localparam int FW         = $clog2(RESULT_CAP + 1);

  // One timer as held by a cell
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] time_left;
    logic [31:0] reload;
    logic [15:0] repeats;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '0;

  // Broadcast command to the chain
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_CLEAR,
    CM_STEP
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t  mode;
    logic [31:0] key;
    entry_t      ent;
  } cell_ctrl_t;

endpackage

>>> rtl/krt_cell.sv
module krt_cell
  import krt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       sel,
  input  logic       prev_lt,
  input  entry_t     prev_ent,
  input  entry_t     next_ent,
  output entry_t     ent,
  output logic       lt,
  output logic       hit
);

  entry_t ent_r;
  entry_t ent_nxt;

  // Compare own key against the broadcast key
  assign lt  = ent_r.valid && (ent_r.key < ctrl.key);
  assign hit = ent_r.valid && (ent_r.key == ctrl.key);
  assign ent = ent_r;

  // Pick next content: hold, take new, take from a neighbor, or clear valid
  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.mode)
      CM_INSERT: begin
        if (!lt) begin
          ent_nxt = prev_lt ? ctrl.ent : prev_ent;
        end
      end
      CM_REMOVE: begin
        if (!lt) begin
          ent_nxt = next_ent;
        end
      end
      CM_CLEAR: begin
        ent_nxt.valid = 1'b0;
      end
      CM_STEP: begin
        ent_nxt = sel ? ctrl.ent : next_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  // Hold valid under reset, payload free-running
  always_ff @(posedge clk) begin
    ent_r.key       <= ent_nxt.key;
    ent_r.time_left <= ent_nxt.time_left;
    ent_r.reload    <= ent_nxt.reload;
    ent_r.repeats   <= ent_nxt.repeats;
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
  end

endmodule

>>> rtl/keyed_repeat_timer_table.sv
// Keyed countdown timer table. Timers live in a row of cells kept sorted by
// ascending key, valid entries packed at the front. Add, remove and clear
// are taken without leaving idle; their single result beat appears on the cycle
// after start, and busy stays low so the next command may follow at once.
// A tick walks the table through the head cell, one timer per cycle, so it
// holds busy while it steps through all live timers and then through the
// flush state that closes it; the next command is taken once it is idle again.
// Fired beats come out in ascending key order, at most one
// per cycle, the last one flagged by out_last; a tick with nothing fired
// gives one "none fired" beat. Results are strobed by out_valid for exactly
// one cycle and cannot be held off, so the receiver must take every beat.
module keyed_repeat_timer_table
  import krt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_timer_key,
  input  logic [31:0]        in_period_us,
  input  logic signed [15:0] in_repeat_count,
  input  logic [23:0]        in_elapsed_us,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [31:0]        out_fired_key,
  output logic               out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_FLUSH
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [23:0] elapsed_r, elapsed_nxt;
  logic [FW-1:0] fired_cnt_r, fired_cnt_nxt;
  logic        have_pend_r, have_pend_nxt;
  logic [31:0] pend_key_r, pend_key_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [31:0] out_key_r, out_key_nxt;
  logic        out_last_r, out_last_nxt;

  cell_ctrl_t      ctrl;
  entry_t          cell_ent [DEPTH];
  entry_t          prev_ent [DEPTH];
  entry_t          next_ent [DEPTH];
  logic [DEPTH-1:0] cell_lt, cell_hit, cell_sel, prev_lt;

  entry_t      head, proc;
  logic        accept, hit_any, full;
  logic        fire, keep;
  logic [15:0] rep_dec;
  logic [IW-1:0] wr_idx;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign hit_any = |cell_hit;
  assign full    = (count_r == CW'(DEPTH));

  // Process the head timer for one tick step
  assign head    = cell_ent[0];
  assign fire    = ({8'd0, elapsed_r} >= head.time_left);
  assign rep_dec = (head.repeats != 16'd0 && !head.repeats[15]) ?
                   head.repeats - 16'd1 : head.repeats;
  assign keep    = !fire || (rep_dec != 16'd0);

  always_comb begin
    proc           = head;
    proc.valid     = keep;
    proc.time_left = fire ? head.reload : head.time_left - {8'd0, elapsed_r};
    proc.repeats   = fire ? rep_dec : head.repeats;
  end

  // Kept timer goes behind the already processed ones
  assign wr_idx = IW'(count_r - CW'(1));

  // Broadcast command to the chain
  always_comb begin
    ctrl.mode = CM_HOLD;
    ctrl.key  = in_timer_key;
    ctrl.ent  = proc;
    if (state_r == S_TICK) begin
      ctrl.mode = CM_STEP;
    end else if (accept) begin
      case (in_operation)
        OP_ADD: begin
          ctrl.ent.valid     = 1'b1;
          ctrl.ent.key       = in_timer_key;
          ctrl.ent.time_left = in_period_us;
          ctrl.ent.reload    = in_period_us;
          ctrl.ent.repeats   = in_repeat_count;
          if (!hit_any && !full) begin
            ctrl.mode = CM_INSERT;
          end
        end
        OP_REMOVE: begin
          if (hit_any) begin
            ctrl.mode = CM_REMOVE;
          end
        end
        OP_CLEAR: begin
          ctrl.mode = CM_CLEAR;
        end
        default: begin
          ctrl.mode = CM_HOLD;
        end
      endcase
    end
  end

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_lt[i]  = 1'b1;
      assign prev_ent[i] = ENTRY_EMPTY;
    end else begin : g_rest
      assign prev_lt[i]  = cell_lt[i-1];
      assign prev_ent[i] = cell_ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_ent[i] = ENTRY_EMPTY;
    end else begin : g_mid
      assign next_ent[i] = cell_ent[i+1];
    end
    assign cell_sel[i] = keep && (wr_idx == IW'(i));

    krt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .sel      (cell_sel[i]),
      .prev_lt  (prev_lt[i]),
      .prev_ent (prev_ent[i]),
      .next_ent (next_ent[i]),
      .ent      (cell_ent[i]),
      .lt       (cell_lt[i]),
      .hit      (cell_hit[i])
    );
  end

  // Sequence commands and result beats
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    elapsed_nxt    = elapsed_r;
    fired_cnt_nxt  = fired_cnt_r;
    have_pend_nxt  = have_pend_r;
    pend_key_nxt   = pend_key_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_key_nxt    = in_timer_key;
    out_last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_TICK: begin
              elapsed_nxt   = in_elapsed_us;
              rem_nxt       = count_r;
              fired_cnt_nxt = '0;
              have_pend_nxt = 1'b0;
              state_nxt     = (count_r == '0) ? S_FLUSH : S_TICK;
            end
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (hit_any) begin
                out_status_nxt = ST_DUP;
              end else if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_ADDED;
                count_nxt      = count_r + CW'(1);
              end
            end
            OP_REMOVE: begin
              out_valid_nxt = 1'b1;
              if (hit_any) begin
                out_status_nxt = ST_REMOVED;
                count_nxt      = count_r - CW'(1);
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_CLEARED;
              count_nxt      = '0;
            end
          endcase
        end
      end
      S_TICK: begin
        // Emit the held beat once a newer one arrives
        if (fire && (fired_cnt_r < FW'(RESULT_CAP))) begin
          if (have_pend_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FIRED;
            out_key_nxt    = pend_key_r;
            out_last_nxt   = 1'b0;
          end
          pend_key_nxt  = head.key;
          have_pend_nxt = 1'b1;
          fired_cnt_nxt = fired_cnt_r + FW'(1);
        end
        if (!keep) begin
          count_nxt = count_r - CW'(1);
        end
        rem_nxt = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // Close the tick with its final beat
        out_valid_nxt  = 1'b1;
        out_status_nxt = have_pend_r ? ST_FIRED : ST_NONE;
        out_key_nxt    = have_pend_r ? pend_key_r : 32'd0;
        have_pend_nxt  = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    elapsed_r    <= elapsed_nxt;
    fired_cnt_r  <= fired_cnt_nxt;
    pend_key_r   <= pend_key_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_fired_key = out_key_r;
  assign out_last      = out_last_r;

endmodule

>>> rtl/krt_checker.sv
module krt_checker
  import krt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [31:0] out_fired_key,
  input logic        out_last
);

  // A command other than tick answers with one final beat next cycle
  a_cmd_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != OP_TICK |=> out_valid && out_last)
    else $error("command not answered by a final beat");

  // More beats follow a non-final beat, so the block is still busy
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final beat while idle");

  // The final beat leaves the block ready
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final beat while busy");

  // A quiet tick reports key zero and ends the item
  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE |-> out_fired_key == 32'd0 && out_last)
    else $error("malformed none-fired beat");

  // Only tick beats can be non-final
  a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_FIRED)
    else $error("non-final beat that is not a fired beat");

endmodule

bind keyed_repeat_timer_table krt_checker u_krt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_operation  (in_operation),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_fired_key (out_fired_key),
  .out_last      (out_last)
);
